>>> rtl/core/assert_macros.svh
// Assertion macros shared by the phase-weighted stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PWS_ASSERT(lbl, aclk, arst_n, prop) \
  lbl: assert property (@(posedge aclk) disable iff (!arst_n) prop) \
    else $error("assertion failed");
`define PWS_NEVER(lbl, aclk, arst_n, cond) \
  lbl: assert property (@(posedge aclk) disable iff (!arst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PWS_ASSERT(lbl, aclk, arst_n, prop)
`define PWS_NEVER(lbl, aclk, arst_n, cond)
`endif
`endif

>>> rtl/core/pws_pkg.sv
// Shared constants for the phase-weighted stack.
`timescale 1ns / 1ps
package pws_pkg;
  localparam int IN_W           = 24;
  localparam int OUT_W          = 32;
  localparam int TC_W           = 9;
  localparam int CP_W           = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 9;
  localparam int Q15_W          = 16;
  localparam int MAX_TRACES_DEF = 256;

  localparam logic [Q15_W-1:0] Q15_ONE  = 16'h8000;
  localparam logic [Q15_W-1:0] Q15_HALF = 16'h4000;
  localparam logic [14:0]      PH_MAX   = 15'h7fff;

  localparam logic [CFG_IDX_W-1:0] REG_TRACE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COH_POWER   = 1'b1;

  localparam logic [TC_W-1:0] TC_RESET = 9'd1;
  localparam logic [CP_W-1:0] CP_RESET = 3'd2;
endpackage

>>> rtl/core/pws_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module pws_isqrt import pws_pkg::*; #(
  parameter int RW = 25
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            busy,
  output logic            done,
  output logic [RW-1:0]   root
);
  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_r;
  logic [RW:0]     rem_r;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic            done_r;
  logic [RW+2:0]   remx;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            ge;

  assign remx  = {rem_r, rad_r[2*RW-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = remx >= trial;
  assign diff  = remx - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1)) && !start;
      if (start) begin
        cnt_r <= CW'(RW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r  <= {rad_r[2*RW-3:0], 2'b00};
      rem_r  <= ge ? diff[RW:0] : remx[RW:0];
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign busy = cnt_r != '0;
  assign done = done_r;
  assign root = root_r;
endmodule

>>> rtl/core/pws_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pws_div import pws_pkg::*; #(
  parameter int DVS_W = 24,
  parameter int Q_W   = 26
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DVS_W+Q_W-1:0]   dividend,
  input  logic [DVS_W-1:0]       divisor,
  output logic                   busy,
  output logic                   done,
  output logic [Q_W-1:0]         quotient
);
  localparam int CW = $clog2(Q_W + 1);

  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dsr_r;
  logic [Q_W-1:0]   quo_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [DVS_W:0]   t;
  logic [DVS_W:0]   diff;
  logic             ge;

  // The upper dividend bits must already be below the divisor.
  assign t    = {rem_r, quo_r[Q_W-1]};
  assign ge   = t >= {1'b0, dsr_r};
  assign diff = t - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1)) && !start;
      if (start) begin
        cnt_r <= CW'(Q_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DVS_W+Q_W-1:Q_W];
      quo_r <= dividend[Q_W-1:0];
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DVS_W-1:0] : t[DVS_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], ge};
    end
  end

  assign busy     = cnt_r != '0;
  assign done     = done_r;
  assign quotient = quo_r;
endmodule

>>> rtl/core/pws_front.sv
// Front end: accepts trace pairs, tags the closing trace and queues them.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pws_front import pws_pkg::*; #(
  parameter int MAX_TRACES = MAX_TRACES_DEF,
  localparam int CNT_W = $clog2(MAX_TRACES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [IN_W-1:0]  in_real_sample,
  input  logic signed [IN_W-1:0]  in_quad_sample,
  input  logic [TC_W-1:0]         trace_count,
  output logic                    item_valid,
  input  logic                    item_ready,
  output logic [IN_W-1:0]         item_real,
  output logic [IN_W-1:0]         item_quad,
  output logic                    item_last,
  output logic [CNT_W-1:0]        item_n
);
  localparam int TW  = (CNT_W > TC_W) ? CNT_W : TC_W;
  localparam int E_W = 2*IN_W + 1 + CNT_W;

  logic [E_W-1:0]   q_mem [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0] n_cur;
  logic [TW-1:0]    tc_w, max_w, target;
  logic             acc, pop, acc_last;
  logic [E_W-1:0]   head;

  assign tc_w   = TW'(trace_count);
  assign max_w  = TW'(MAX_TRACES);
  assign target = (tc_w == '0) ? TW'(1) : ((tc_w > max_w) ? max_w : tc_w);
  assign n_cur  = seen_r + 1'b1;
  assign acc_last = TW'(n_cur) >= target;

  assign in_full    = cnt_r == 2'd2;
  assign item_valid = cnt_r != 2'd0;
  assign acc        = in_push && !in_full;
  assign pop        = item_valid && item_ready;

  always_comb begin
    seen_nxt = seen_r;
    if (acc) begin
      seen_nxt = acc_last ? '0 : n_cur;
    end
    cnt_nxt = cnt_r;
    case ({acc, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      cnt_r  <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      cnt_r  <= cnt_nxt;
      if (acc) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_mem[wp_r] <= {in_real_sample, in_quad_sample, acc_last, n_cur};
    end
  end

  assign head      = q_mem[rp_r];
  assign item_real = head[E_W-1 -: IN_W];
  assign item_quad = head[E_W-IN_W-1 -: IN_W];
  assign item_last = head[CNT_W];
  assign item_n    = head[CNT_W-1:0];

  `PWS_NEVER(a_cnt_range, clk, rst_n, cnt_r > 2'd2)
  `PWS_ASSERT(a_last_clears, clk, rst_n, (acc && acc_last) |=> (seen_r == '0))
  `PWS_NEVER(a_seen_bound, clk, rst_n, 32'(seen_r) >= MAX_TRACES)
endmodule

>>> rtl/core/pws_back.sv
// Back end: phasor normalization, accumulation and the closing weight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pws_back import pws_pkg::*; #(
  parameter int MAX_TRACES = MAX_TRACES_DEF,
  localparam int CNT_W = $clog2(MAX_TRACES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic [IN_W-1:0]         item_real,
  input  logic [IN_W-1:0]         item_quad,
  input  logic                    item_last,
  input  logic [CNT_W-1:0]        item_n,
  input  logic [CP_W-1:0]         coherence_power,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [OUT_W-1:0] out_stacked_sample
);
  localparam int PSUM_W = Q15_W + CNT_W;
  localparam int SS_W   = IN_W + CNT_W;
  localparam int SQ_IN  = (PSUM_W > IN_W) ? PSUM_W : IN_W;
  localparam int QW     = (PSUM_W + 1 > IN_W) ? PSUM_W + 1 : IN_W;
  localparam int DD_W   = IN_W + QW;
  localparam int P_W    = SS_W + Q15_W;
  localparam int AN_W   = P_W + 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SQ    = 13'b0000000000010,
    S_ROOT  = 13'b0000000000100,
    S_DIV   = 13'b0000000001000,
    S_ACC   = 13'b0000000010000,
    S_FSQ   = 13'b0000000100000,
    S_FROOT = 13'b0000001000000,
    S_COH   = 13'b0000010000000,
    S_POW   = 13'b0000100000000,
    S_MUL   = 13'b0001000000000,
    S_OGO   = 13'b0010000000000,
    S_ODIV  = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IN_W-1:0]   r_r, q_r;
  logic              last_r, zero_r;
  logic [CNT_W-1:0]  n_r;
  logic [PSUM_W-1:0] psr_r, psq_r;
  logic [SS_W-1:0]   ss_r;
  logic [Q15_W-1:0]  coh_r, w_r;
  logic [CP_W-1:0]   k_r;
  logic [P_W-1:0]    p_r;
  logic              sneg_r;
  logic [OUT_W-1:0]  res_r;
  logic              res_valid_r;

  logic [IN_W-1:0]    ar, aq;
  logic [PSUM_W-1:0]  apsr, apsq;
  logic [SS_W-1:0]    ass;
  logic [SQ_IN-1:0]   sa, sb;
  logic [2*SQ_IN-1:0] sqa, sqb, radicand;
  logic               root_start, root_busy, root_done;
  logic [SQ_IN-1:0]   root;
  logic [IN_W-1:0]    mag;
  logic               div_start_a, div_start_b, div_busy_a, div_done_a, div_done_b;
  logic               div_busy_b;
  logic [DD_W-1:0]    dvd_a, dvd_b;
  logic [IN_W-1:0]    dsr_a;
  logic [QW-1:0]      quo_a, quo_b;
  logic [AN_W-1:0]    an;
  logic [14:0]        pa, pb;
  logic [PSUM_W-1:0]  ma, mb, phr_v, phq_v;
  logic [31:0]        wmul;
  logic [32:0]        wprod;
  logic [OUT_W-1:0]   qv;
  logic               emit_fire;

  assign ar   = r_r[IN_W-1] ? (~r_r + 1'b1) : r_r;
  assign aq   = q_r[IN_W-1] ? (~q_r + 1'b1) : q_r;
  assign apsr = psr_r[PSUM_W-1] ? (~psr_r + 1'b1) : psr_r;
  assign apsq = psq_r[PSUM_W-1] ? (~psq_r + 1'b1) : psq_r;
  assign ass  = ss_r[SS_W-1] ? (~ss_r + 1'b1) : ss_r;

  // One squaring pair serves both the trace magnitude and the sum magnitude.
  assign sa  = (state_r == S_FSQ) ? SQ_IN'(apsr) : SQ_IN'(ar);
  assign sb  = (state_r == S_FSQ) ? SQ_IN'(apsq) : SQ_IN'(aq);
  assign sqa = (2*SQ_IN)'(sa) * (2*SQ_IN)'(sa);
  assign sqb = (2*SQ_IN)'(sb) * (2*SQ_IN)'(sb);
  assign radicand   = sqa + sqb;
  assign root_start = (state_r == S_SQ) || (state_r == S_FSQ);
  assign mag        = root[IN_W-1:0];

  pws_isqrt #(.RW(SQ_IN)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .busy     (root_busy),
    .done     (root_done),
    .root     (root)
  );

  assign an = AN_W'(p_r) + AN_W'({n_r, 14'b0});

  always_comb begin
    dvd_a = DD_W'({ar, 15'b0}) + DD_W'(mag >> 1);
    dsr_a = mag;
    if (state_r == S_FROOT) begin
      dvd_a = DD_W'(root[PSUM_W-1:0]) + DD_W'(n_r >> 1);
      dsr_a = IN_W'(n_r);
    end else if (state_r == S_OGO) begin
      dvd_a = DD_W'(an >> 15);
      dsr_a = IN_W'(n_r);
    end
  end
  assign dvd_b = DD_W'({aq, 15'b0}) + DD_W'(mag >> 1);

  assign div_start_b = (state_r == S_ROOT) && root_done && (mag != '0);
  assign div_start_a = div_start_b || ((state_r == S_FROOT) && root_done) ||
                       (state_r == S_OGO);

  pws_div #(.DVS_W(IN_W), .Q_W(QW)) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_a),
    .dividend (dvd_a),
    .divisor  (dsr_a),
    .busy     (div_busy_a),
    .done     (div_done_a),
    .quotient (quo_a)
  );

  pws_div #(.DVS_W(IN_W), .Q_W(QW)) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_b),
    .dividend (dvd_b),
    .divisor  (mag),
    .busy     (div_busy_b),
    .done     (div_done_b),
    .quotient (quo_b)
  );

  // Phasor components are clamped to the largest Q1.15 magnitude.
  assign pa    = (quo_a > QW'(PH_MAX)) ? PH_MAX : quo_a[14:0];
  assign pb    = (quo_b > QW'(PH_MAX)) ? PH_MAX : quo_b[14:0];
  assign ma    = PSUM_W'(pa);
  assign mb    = PSUM_W'(pb);
  assign phr_v = zero_r ? '0 : (r_r[IN_W-1] ? (~ma + 1'b1) : ma);
  assign phq_v = zero_r ? '0 : (q_r[IN_W-1] ? (~mb + 1'b1) : mb);

  assign wmul  = 32'(w_r) * 32'(coh_r);
  assign wprod = {1'b0, wmul} + 33'(Q15_HALF);

  assign qv        = OUT_W'(quo_a[IN_W-1:0]);
  assign emit_fire = (state_r == S_EMIT) && (!res_valid_r || out_pop);
  assign item_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (item_valid) state_nxt = S_SQ;
      S_SQ:    state_nxt = S_ROOT;
      S_ROOT:  if (root_done) state_nxt = (mag == '0) ? S_ACC : S_DIV;
      S_DIV:   if (div_done_a && div_done_b) state_nxt = S_ACC;
      S_ACC:   state_nxt = last_r ? S_FSQ : S_IDLE;
      S_FSQ:   state_nxt = S_FROOT;
      S_FROOT: if (root_done) state_nxt = S_COH;
      S_COH:   if (div_done_a) state_nxt = S_POW;
      S_POW:   if (k_r >= coherence_power) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_OGO;
      S_OGO:   state_nxt = S_ODIV;
      S_ODIV:  if (div_done_a) state_nxt = S_EMIT;
      S_EMIT:  if (emit_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      psr_r       <= '0;
      psq_r       <= '0;
      ss_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= (res_valid_r && !out_pop) || emit_fire;
      if (state_r == S_ACC) begin
        psr_r <= psr_r + phr_v;
        psq_r <= psq_r + phq_v;
        ss_r  <= ss_r + {{CNT_W{r_r[IN_W-1]}}, r_r};
      end else if (emit_fire) begin
        psr_r <= '0;
        psq_r <= '0;
        ss_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && item_valid) begin
      r_r    <= item_real;
      q_r    <= item_quad;
      last_r <= item_last;
      n_r    <= item_n;
    end
    if ((state_r == S_ROOT) && root_done) begin
      zero_r <= mag == '0;
    end
    if ((state_r == S_COH) && div_done_a) begin
      coh_r <= (quo_a > QW'(Q15_ONE)) ? Q15_ONE : quo_a[Q15_W-1:0];
      w_r   <= Q15_ONE;
      k_r   <= '0;
    end
    if ((state_r == S_POW) && (k_r < coherence_power)) begin
      w_r <= wprod[15 +: Q15_W];
      k_r <= k_r + 1'b1;
    end
    if (state_r == S_MUL) begin
      p_r    <= P_W'(ass) * P_W'(w_r);
      sneg_r <= ss_r[SS_W-1];
    end
    if (emit_fire) begin
      res_r <= sneg_r ? (~qv + 1'b1) : qv;
    end
  end

  assign out_empty          = !res_valid_r;
  assign out_stacked_sample = res_r;

  `PWS_NEVER(a_coh_range, clk, rst_n, (state_r == S_POW) && (coh_r > Q15_ONE))
  `PWS_ASSERT(a_res_hold, clk, rst_n, (res_valid_r && !out_pop) |=> (res_valid_r && $stable(res_r)))
  `PWS_NEVER(a_root_overlap, clk, rst_n, root_start && root_busy)
  `PWS_NEVER(a_div_overlap, clk, rst_n, div_start_a && div_busy_a)
  `PWS_NEVER(a_div_b_overlap, clk, rst_n, div_start_b && div_busy_b)
endmodule

>>> rtl/core/phase_weighted_stack.sv
// Phase-weighted stack top level: configuration registers, front end and back end.
// In the back end each trace pair goes through the serial square root and then,
// unless its magnitude is zero, the two parallel dividers. The closing trace adds
// a sum square root, a coherence division, the power loop and an output division.
// A two-entry queue takes new pairs while the back end works and a result waits.
// Reset is synchronous and active low: registers return to trace_count 1 and power 2.
`timescale 1ns / 1ps
module phase_weighted_stack import pws_pkg::*; #(
  parameter int MAX_TRACES = MAX_TRACES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [IN_W-1:0]  in_real_sample,
  input  logic signed [IN_W-1:0]  in_quad_sample,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [OUT_W-1:0] out_stacked_sample,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);
  localparam int CNT_W = $clog2(MAX_TRACES + 1);

  logic [TC_W-1:0]  trace_count_r;
  logic [CP_W-1:0]  coherence_power_r;
  logic             item_valid, item_ready, item_last;
  logic [IN_W-1:0]  item_real, item_quad;
  logic [CNT_W-1:0] item_n;

  // Always accepted; the user must issue configuration transfers only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_count_r     <= TC_RESET;
      coherence_power_r <= CP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRACE_COUNT: trace_count_r     <= cfg_data[TC_W-1:0];
        REG_COH_POWER:   coherence_power_r <= cfg_data[CP_W-1:0];
        default:         ;
      endcase
    end
  end

  // The front end counts traces and marks the one that closes the stack, so the
  // back end never needs to look at trace_count.
  pws_front #(.MAX_TRACES(MAX_TRACES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_real_sample (in_real_sample),
    .in_quad_sample (in_quad_sample),
    .trace_count    (trace_count_r),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item_real      (item_real),
    .item_quad      (item_quad),
    .item_last      (item_last),
    .item_n         (item_n)
  );

  // The back end normalizes each pair to a unit phasor, accumulates, and on the
  // closing trace weights the mean sample by the coherence raised to the power.
  // The mean never leaves the 24-bit sample range, so the 32-bit result holds it.
  pws_back #(.MAX_TRACES(MAX_TRACES)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .item_real          (item_real),
    .item_quad          (item_quad),
    .item_last          (item_last),
    .item_n             (item_n),
    .coherence_power    (coherence_power_r),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_stacked_sample (out_stacked_sample)
  );
endmodule
